// ===== hw/rtl/spq_pkg.sv =====
// Package for the sorted priority queue: sizes, codes and transfer types.
// Used by spq_cell and sorted_priority_queue_core; it depends on nothing else.
package spq_pkg;

    // Queue depth and the width of the fill count, which must hold DEPTH itself.
    localparam int DEPTH   = 8;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int OCC_W   = 4;

    // Operation codes carried by a command transfer.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // One command item.
    typedef struct packed {
        logic               operation;
        logic signed [31:0] element;
        logic        [7:0]  prio;
    } cmd_t;

    // One result item.
    typedef struct packed {
        logic        [1:0]       status;
        logic signed [31:0]      out_element;
        logic        [7:0]       out_prio;
        logic        [OCC_W-1:0] occupancy;
    } res_t;

    // One stored entry of the queue.
    typedef struct packed {
        logic signed [31:0] value;
        logic        [7:0]  prio;
    } entry_t;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic   ins;
        logic   rem;
        entry_t item;
    } cell_ctl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// One cell of the sorted queue chain: holds a single entry and shifts it
// towards its neighbours on insert and remove. Depends on spq_pkg.
module spq_cell
(
    input  logic               clk,
    input  spq_pkg::cell_ctl_t ctl,
    input  logic               occupied,
    input  logic               left_lower,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t    entry,
    output logic               lower
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // An empty cell, or one of strictly lower priority, yields to the new item.
    assign lower = !occupied || (entry_reg.prio < ctl.item.prio);
    assign entry = entry_reg;

    // On insert a yielding cell takes its left neighbour, or the new item if it
    // is the first to yield. On remove every cell takes its right neighbour; the tail keeps its own.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins && lower)
        begin
            entry_next = left_lower ? left_entry : ctl.item;
        end
        else if (ctl.rem)
        begin
            entry_next = right_entry;
        end
    end

    // Payload only, so no reset.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== hw/rtl/sorted_priority_queue_core.sv =====
// Sorted priority queue, highest priority first, equal priorities in arrival order.
// The result is registered and shows in the cycle after the command transfer; one command
// per cycle while results are taken, set by the compare and shift across the cells.
// A command is taken while a result waits, provided that result is taken in the same cycle.
// Reset (rst_n low, asynchronous) empties the queue and drops any pending result;
// stored entries are not cleared, only the fill count.
module sorted_priority_queue_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  spq_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_stall,
    output spq_pkg::res_t res
);

    logic [spq_pkg::COUNT_W-1:0] count_reg;
    logic [spq_pkg::COUNT_W-1:0] count_next;
    logic                        res_valid_reg;
    spq_pkg::res_t               res_reg;
    spq_pkg::res_t               res_next;

    logic                        accept;
    logic                        full;
    logic                        empty;
    spq_pkg::cell_ctl_t          ctl;

    spq_pkg::entry_t             entries [spq_pkg::DEPTH];
    logic                        lowers  [spq_pkg::DEPTH];

    // Handshake: the result register frees up when its transfer completes.
    assign cmd_stall = res_valid_reg && res_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign full  = (count_reg == spq_pkg::COUNT_W'(spq_pkg::DEPTH));
    assign empty = (count_reg == '0);

    // Control broadcast to the chain.
    always_comb
    begin
        ctl.ins        = accept && (cmd.operation == spq_pkg::OP_INSERT) && !full;
        ctl.rem        = accept && (cmd.operation == spq_pkg::OP_REMOVE) && !empty;
        ctl.item.value = cmd.element;
        ctl.item.prio  = cmd.prio;
    end

    // The chain of cells, head at index zero.
    for (genvar i = 0; i < spq_pkg::DEPTH; i++)
    begin : g_cell
        logic            occupied;
        logic            left_lower;
        spq_pkg::entry_t left_entry;
        spq_pkg::entry_t right_entry;

        assign occupied = (spq_pkg::COUNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign left_lower = 1'b0;
            assign left_entry = ctl.item;
        end
        else
        begin : g_body
            assign left_lower = lowers[i-1];
            assign left_entry = entries[i-1];
        end

        if (i == spq_pkg::DEPTH - 1)
        begin : g_tail
            assign right_entry = entries[i];
        end
        else
        begin : g_inner
            assign right_entry = entries[i+1];
        end

        spq_cell u_cell
        (
            .clk         (clk),
            .ctl         (ctl),
            .occupied    (occupied),
            .left_lower  (left_lower),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entries[i]),
            .lower       (lowers[i])
        );
    end

    // Fill count and the result of the command being taken.
    always_comb
    begin
        count_next = count_reg;
        if (ctl.ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.rem)
        begin
            count_next = count_reg - 1'b1;
        end

        res_next.status      = spq_pkg::ST_OK;
        res_next.out_element = '0;
        res_next.out_prio    = '0;
        if (cmd.operation == spq_pkg::OP_REMOVE)
        begin
            if (empty)
            begin
                res_next.status = spq_pkg::ST_UNDERFLOW;
            end
            else
            begin
                res_next.out_element = entries[0].value;
                res_next.out_prio    = entries[0].prio;
            end
        end
        else if (full)
        begin
            res_next.status = spq_pkg::ST_OVERFLOW;
        end
        res_next.occupancy = spq_pkg::OCC_W'(count_next);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    // The fill count never passes the depth.
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= spq_pkg::COUNT_W'(spq_pkg::DEPTH))
        else $error("fill count above depth");

    // A successful insert grows the queue by one.
    a_insert_grows : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the queue");

    // A remove from an empty queue reports underflow and leaves it empty.
    a_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.operation == spq_pkg::OP_REMOVE) && empty)
        |=> (res.status == spq_pkg::ST_UNDERFLOW) && (count_reg == '0) && res_valid)
        else $error("underflow not reported");

    // With no result waiting, commands are never held off.
    a_no_stall_idle : assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid_reg |-> !cmd_stall)
        else $error("command stalled with no result pending");

endmodule
